// ----- hdl/csc_pkg.sv -----
`default_nettype none

package csc_pkg;

    localparam int POS_BITS  = 24;
    localparam int REST_W    = 50;
    localparam int STIFF_W   = 16;
    localparam int DT_W      = 16;
    localparam int FRAC_W    = 16;

    // link magnitude holds 2^POS_BITS
    localparam int LMAG_W    = POS_BITS + 1;
    localparam int SQ_W      = 2 * LMAG_W;
    localparam int D_W       = 64;
    localparam int SUM_W     = D_W + 2;
    localparam int R100_W    = REST_W + 7;
    localparam int INT_STEPS = 3;
    localparam int DIV_STEPS = INT_STEPS + FRAC_W;
    localparam int REM_W     = D_W + INT_STEPS;
    localparam int Q_W       = DIV_STEPS;
    localparam int FMAG_W    = Q_W + 1;
    localparam int P1_W      = FMAG_W + STIFF_W;
    localparam int P2_W      = P1_W + DT_W;
    localparam int SCALE_SH  = 30;
    localparam int SCALE_W   = P2_W - SCALE_SH;
    localparam int SPROD_W   = LMAG_W + SCALE_W;
    localparam int STEP_W    = SPROD_W - FRAC_W;
    localparam int ACC_W     = STEP_W + 2;

    localparam logic [FMAG_W-1:0] FRAC_SAT = FMAG_W'(524288);
    localparam logic [6:0]        BREAK_MUL = 7'd100;

    typedef struct packed {
        logic signed [POS_BITS-1:0] start_x;
        logic signed [POS_BITS-1:0] start_y;
        logic signed [POS_BITS-1:0] start_z;
        logic signed [POS_BITS-1:0] end_x;
        logic signed [POS_BITS-1:0] end_y;
        logic signed [POS_BITS-1:0] end_z;
        logic                       start_fixed;
        logic                       end_fixed;
        logic [REST_W-1:0]          rest_sq;
        logic [STIFF_W-1:0]         stiffness;
        logic [DT_W-1:0]            delta_time;
        logic                       connected;
    } t_in_item;

    typedef struct packed {
        logic signed [POS_BITS-1:0] new_start_x;
        logic signed [POS_BITS-1:0] new_start_y;
        logic signed [POS_BITS-1:0] new_start_z;
        logic signed [POS_BITS-1:0] new_end_x;
        logic signed [POS_BITS-1:0] new_end_y;
        logic signed [POS_BITS-1:0] new_end_z;
        logic                       still_connected;
        logic                       link_broke;
    } t_out_item;

endpackage

`default_nettype wire

// ----- hdl/cloth_spring_constraint_step.sv -----
// Pipeline: one stage for capture, four for length and break test, 19 for the
// one-bit-per-stage divider, three for the scale and step multipliers, and one
// for the final add/saturate.
// Throughput: one link per cycle; a stall on the output freezes the whole pipe.
// Reset (synchronous, active low) clears only the stage valid bits.
`default_nettype none

module cloth_spring_constraint_step (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire csc_pkg::t_in_item    i_item,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output csc_pkg::t_out_item        o_item
);

    localparam int P  = csc_pkg::POS_BITS;
    localparam int NS = csc_pkg::DIV_STEPS;

    typedef struct packed {
        csc_pkg::t_in_item                          item;
        logic                                       active;
        logic [2:0][csc_pkg::LMAG_W-1:0]            lmag;
        logic [2:0]                                 lneg;
        logic [2:0][csc_pkg::SQ_W-1:0]              sq;
        logic [csc_pkg::R100_W-1:0]                 r100;
        logic [csc_pkg::D_W-1:0]                    d;
        logic                                       broke;
        logic                                       fneg;
        logic                                       move;
        logic                                       sat;
        logic [csc_pkg::REM_W-1:0]                  rem;
        logic [csc_pkg::Q_W-1:0]                    q;
        logic [csc_pkg::P1_W-1:0]                   p1;
        logic [csc_pkg::SCALE_W-1:0]                scale;
        logic [2:0][csc_pkg::STEP_W-1:0]            stepm;
    } t_pipe;

    function automatic logic signed [P-1:0] sat_pos(
        input logic signed [csc_pkg::ACC_W-1:0] v
    );
        logic signed [csc_pkg::ACC_W-1:0] hi;
        logic signed [csc_pkg::ACC_W-1:0] lo;
        hi = {{(csc_pkg::ACC_W-P+1){1'b0}}, {(P-1){1'b1}}};
        lo = ~hi;
        if (v > hi) begin
            return hi[P-1:0];
        end else if (v < lo) begin
            return lo[P-1:0];
        end
        return v[P-1:0];
    endfunction

    logic en;
    logic r_v0, r_v1, r_v2, r_v3, r_v4, r_vm1, r_vm2, r_vm3, r_out_v;
    logic [NS-1:0] r_vdv;
    t_pipe r_p0, r_p1, r_p2, r_p3, r_p4, r_m1, r_m2, r_m3;
    t_pipe n_p0, n_p1, n_p2, n_p3, n_p4, n_m1, n_m2, n_m3;
    t_pipe r_dv [NS];
    t_pipe n_dv [NS];
    csc_pkg::t_out_item r_out, n_out;

    assign en      = !(r_out_v && i_stall);
    assign o_stall = !en;
    assign o_valid = r_out_v;
    assign o_item  = r_out;

    always_comb begin
        n_p0      = '0;
        n_p0.item = i_item;
    end

    // link vector, its magnitude and the active flag
    always_comb begin
        logic [P:0] lk;
        logic signed [P-1:0] s_ax [3];
        logic signed [P-1:0] e_ax [3];
        n_p1 = r_p0;
        s_ax[0] = r_p0.item.start_x;
        s_ax[1] = r_p0.item.start_y;
        s_ax[2] = r_p0.item.start_z;
        e_ax[0] = r_p0.item.end_x;
        e_ax[1] = r_p0.item.end_y;
        e_ax[2] = r_p0.item.end_z;
        for (int i = 0; i < 3; i++) begin
            lk = {e_ax[i][P-1], e_ax[i]} - {s_ax[i][P-1], s_ax[i]};
            n_p1.lneg[i] = lk[P];
            n_p1.lmag[i] = lk[P] ? (~lk + 1'b1) : lk;
        end
        n_p1.active = r_p0.item.connected
                    && !(r_p0.item.start_fixed && r_p0.item.end_fixed);
    end

    always_comb begin
        n_p2 = r_p1;
        for (int i = 0; i < 3; i++) begin
            n_p2.sq[i] = r_p1.lmag[i] * r_p1.lmag[i];
        end
        n_p2.r100 = csc_pkg::R100_W'(r_p1.item.rest_sq) * csc_pkg::R100_W'(csc_pkg::BREAK_MUL);
    end

    always_comb begin
        logic [csc_pkg::SUM_W-1:0] sum;
        n_p3 = r_p2;
        sum  = csc_pkg::SUM_W'(r_p2.sq[0]) + csc_pkg::SUM_W'(r_p2.sq[1])
             + csc_pkg::SUM_W'(r_p2.sq[2]);
        n_p3.d = (sum[csc_pkg::SUM_W-1:csc_pkg::D_W] != '0) ? '1 : sum[csc_pkg::D_W-1:0];
    end

    always_comb begin
        logic [csc_pkg::D_W-1:0] r_ext;
        logic [csc_pkg::D_W-1:0] num;
        n_p4 = r_p3;
        r_ext = csc_pkg::D_W'(r_p3.item.rest_sq);
        n_p4.broke = r_p3.active && (r_p3.d > csc_pkg::D_W'(r_p3.r100));
        n_p4.fneg  = r_p3.d < r_ext;
        num = n_p4.fneg ? (r_ext - r_p3.d) : (r_p3.d - r_ext);
        n_p4.rem  = csc_pkg::REM_W'(num);
        n_p4.q    = '0;
        n_p4.sat  = 1'b0;
        n_p4.move = r_p3.active && !n_p4.broke && (r_p3.d != '0);
    end

    // restoring divider, one quotient bit per stage
    for (genvar j = 0; j < NS; j++) begin : g_div
        always_comb begin
            t_pipe src;
            logic [csc_pkg::REM_W-1:0] rr;
            logic [csc_pkg::REM_W-1:0] dv;
            src = (j == 0) ? r_p4 : r_dv[(j == 0) ? 0 : j-1];
            n_dv[j] = src;
            if (j == 0) begin
                n_dv[j].sat = src.fneg
                            && (src.rem >= {src.d, {csc_pkg::INT_STEPS{1'b0}}});
            end
            if (j < csc_pkg::INT_STEPS) begin
                rr = src.rem;
                dv = csc_pkg::REM_W'(src.d) << (csc_pkg::INT_STEPS - 1 - j);
            end else begin
                rr = src.rem << 1;
                dv = csc_pkg::REM_W'(src.d);
            end
            if (rr >= dv) begin
                n_dv[j].rem = rr - dv;
                n_dv[j].q   = {src.q[csc_pkg::Q_W-2:0], 1'b1};
            end else begin
                n_dv[j].rem = rr;
                n_dv[j].q   = {src.q[csc_pkg::Q_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        logic [csc_pkg::FMAG_W-1:0] fmag;
        n_m1 = r_dv[NS-1];
        fmag = r_dv[NS-1].sat ? csc_pkg::FRAC_SAT : csc_pkg::FMAG_W'(r_dv[NS-1].q);
        n_m1.p1 = fmag * csc_pkg::P1_W'(r_dv[NS-1].item.stiffness);
    end

    always_comb begin
        logic [csc_pkg::P2_W-1:0] prod;
        n_m2 = r_m1;
        prod = csc_pkg::P2_W'(r_m1.p1) * csc_pkg::P2_W'(r_m1.item.delta_time);
        n_m2.scale = prod[csc_pkg::P2_W-1:csc_pkg::SCALE_SH];
    end

    always_comb begin
        logic [csc_pkg::SPROD_W-1:0] prod;
        n_m3 = r_m2;
        for (int i = 0; i < 3; i++) begin
            prod = csc_pkg::SPROD_W'(r_m2.lmag[i]) * csc_pkg::SPROD_W'(r_m2.scale);
            n_m3.stepm[i] = prod[csc_pkg::SPROD_W-1:csc_pkg::FRAC_W];
        end
    end

    always_comb begin
        logic signed [P-1:0] s_ax [3];
        logic signed [P-1:0] e_ax [3];
        logic signed [P-1:0] ns_ax [3];
        logic signed [P-1:0] ne_ax [3];
        logic signed [csc_pkg::ACC_W-1:0] stp;
        logic signed [csc_pkg::ACC_W-1:0] sa;
        logic signed [csc_pkg::ACC_W-1:0] ea;
        s_ax[0] = r_m3.item.start_x;
        s_ax[1] = r_m3.item.start_y;
        s_ax[2] = r_m3.item.start_z;
        e_ax[0] = r_m3.item.end_x;
        e_ax[1] = r_m3.item.end_y;
        e_ax[2] = r_m3.item.end_z;
        for (int i = 0; i < 3; i++) begin
            stp = $signed({2'b00, r_m3.stepm[i]});
            if (r_m3.lneg[i] != r_m3.fneg) begin
                stp = -stp;
            end
            sa = csc_pkg::ACC_W'(s_ax[i]) + stp;
            ea = csc_pkg::ACC_W'(e_ax[i]) - stp;
            ns_ax[i] = (r_m3.move && !r_m3.item.start_fixed) ? sat_pos(sa) : s_ax[i];
            ne_ax[i] = (r_m3.move && !r_m3.item.end_fixed)   ? sat_pos(ea) : e_ax[i];
        end
        n_out.new_start_x     = ns_ax[0];
        n_out.new_start_y     = ns_ax[1];
        n_out.new_start_z     = ns_ax[2];
        n_out.new_end_x       = ne_ax[0];
        n_out.new_end_y       = ne_ax[1];
        n_out.new_end_z       = ne_ax[2];
        n_out.still_connected = r_m3.item.connected && !r_m3.broke;
        n_out.link_broke      = r_m3.broke;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_vdv   <= '0;
            r_vm1   <= 1'b0;
            r_vm2   <= 1'b0;
            r_vm3   <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_v0    <= i_valid;
            r_v1    <= r_v0;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_vdv   <= {r_vdv[NS-2:0], r_v4};
            r_vm1   <= r_vdv[NS-1];
            r_vm2   <= r_vm1;
            r_vm3   <= r_vm2;
            r_out_v <= r_vm3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p0      <= n_p0;
            r_p1      <= n_p1;
            r_p2      <= n_p2;
            r_p3      <= n_p3;
            r_p4      <= n_p4;
            for (int j = 0; j < NS; j++) begin
                r_dv[j] <= n_dv[j];
            end
            r_m1      <= n_m1;
            r_m2      <= n_m2;
            r_m3      <= n_m3;
            r_out     <= n_out;
        end
    end

endmodule

`default_nettype wire
